// ===== hdl/lga_pkg.sv =====
// Shared types, constants and codes for the life automaton grid.
`timescale 1ns / 1ps
package lga_pkg;

  localparam int ROWS   = 16;
  localparam int COLS   = 16;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int IDX_W  = 4;
  localparam int FUNC_W = 2;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] BIRTH_CNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURV_CNT  = CNT_W'(2);

  typedef logic [COLS-1:0] row_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET  = 2'd0,
    FN_CLR  = 2'd1,
    FN_READ = 2'd2,
    FN_STEP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_FIRST,
    ST_CALC,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/lga_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lga_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lga_row_rule.sv =====
// B3/S23 rule applied to one row from its upper, own and lower old rows.
`timescale 1ns / 1ps
module lga_row_rule (
  input  lga_pkg::row_t prev_row,
  input  lga_pkg::row_t cur_row,
  input  lga_pkg::row_t next_row,
  output lga_pkg::row_t new_row
);

  logic [lga_pkg::COLS+1:0] prev_pad;
  logic [lga_pkg::COLS+1:0] cur_pad;
  logic [lga_pkg::COLS+1:0] next_pad;
  logic [lga_pkg::CNT_W-1:0] cnt [lga_pkg::COLS];

  assign prev_pad = {1'b0, prev_row, 1'b0};
  assign cur_pad  = {1'b0, cur_row, 1'b0};
  assign next_pad = {1'b0, next_row, 1'b0};

  always_comb begin
    for (int c = 0; c < lga_pkg::COLS; c++) begin
      cnt[c] = lga_pkg::CNT_W'(prev_pad[c]) + lga_pkg::CNT_W'(prev_pad[c+1])
             + lga_pkg::CNT_W'(prev_pad[c+2]) + lga_pkg::CNT_W'(cur_pad[c])
             + lga_pkg::CNT_W'(cur_pad[c+2]) + lga_pkg::CNT_W'(next_pad[c])
             + lga_pkg::CNT_W'(next_pad[c+1]) + lga_pkg::CNT_W'(next_pad[c+2]);
      new_row[c] = (cnt[c] == lga_pkg::BIRTH_CNT)
                || (cur_row[c] && (cnt[c] == lga_pkg::SURV_CNT));
    end
  end

endmodule

// ===== hdl/life_automaton_grid_top.sv =====
// Top level of the life automaton grid: sequencer, row buffers and result register.
//
// Usage:
//   Input channel (in_valid/in_stall, in_func, in_cell_row, in_cell_col) takes one
//   command per transfer: set a cell alive, set it dead, read it, or advance the
//   whole grid one B3/S23 generation (no wrap; outside cells are dead).
//   Result channel (out_valid/out_stall, out_alive, out_step_done) returns exactly
//   one transfer per command, in order.
//   A cell write or read first reads the row from the grid RAM, then modifies it,
//   writes it back and registers the result once the output register is free.
//   A generation step reads the top row, buffers it, then handles one row per cycle
//   with the old upper and current rows held while the lower row is read (the single
//   RAM read port sets the rate), and last registers the result.
//   Commands are taken one at a time; in_stall is high while a command is in work.
//   A new command is taken while a finished result still waits on out_stall;
//   its result then waits in the sequencer until the output register frees.
//   Reset clears the per-row valid flags, so the grid reads as all dead at once;
//   no clearing sweep is needed.
`timescale 1ns / 1ps
module life_automaton_grid_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lga_pkg::FUNC_W-1:0] in_func,
  input  logic [lga_pkg::IDX_W-1:0]  in_cell_row,
  input  logic [lga_pkg::IDX_W-1:0]  in_cell_col,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_alive,
  output logic                      out_step_done
);

  lga_pkg::state_t state_r, state_nxt;
  lga_pkg::func_t  func_r, func_in;
  logic [lga_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [lga_pkg::COL_W-1:0] col_r;
  logic                      inrange_r;
  logic [lga_pkg::ROWS-1:0]  vld_r;
  logic                      rd_vld_r;
  lga_pkg::row_t             prev_r, cur_r;
  logic                      out_valid_r, out_alive_r, out_step_done_r;

  logic                      accept;
  logic                      out_free;
  logic                      rd_in_range;
  logic                      last_row;
  logic [lga_pkg::ROW_W:0]   row_plus2;

  logic                      ram_wr_en;
  logic [lga_pkg::ROW_W-1:0] ram_wr_addr, ram_rd_addr;
  lga_pkg::row_t             ram_wr_data, ram_rd_data;
  lga_pkg::row_t             rd_row, lower_row, rule_row, cell_row_mod;

  logic                      out_load, out_alive_val, out_step_val;
  logic                      shift_rows, load_cur, cell_wr;

  assign func_in     = lga_pkg::func_t'(in_func);
  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != lga_pkg::ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign rd_in_range = (int'(in_cell_row) < lga_pkg::ROWS)
                    && (int'(in_cell_col) < lga_pkg::COLS);
  assign last_row    = (row_r == lga_pkg::ROW_W'(lga_pkg::ROWS - 1));
  assign row_plus2   = {1'b0, row_r} + (lga_pkg::ROW_W + 1)'(2);

  assign rd_row    = rd_vld_r ? ram_rd_data : '0;
  assign lower_row = last_row ? '0 : rd_row;

  always_comb begin
    cell_row_mod = rd_row;
    case (func_r)
      lga_pkg::FN_SET: cell_row_mod[col_r] = 1'b1;
      lga_pkg::FN_CLR: cell_row_mod[col_r] = 1'b0;
      default:         cell_row_mod = rd_row;
    endcase
  end

  lga_row_rule u_rule (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (lower_row),
    .new_row  (rule_row)
  );

  lga_ram #(
    .WIDTH (lga_pkg::COLS),
    .DEPTH (lga_pkg::ROWS)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lga_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (func_in == lga_pkg::FN_STEP) ? lga_pkg::ST_FIRST : lga_pkg::ST_CELL;
        end
      end
      lga_pkg::ST_CELL: begin
        if (out_free) begin
          state_nxt = lga_pkg::ST_IDLE;
        end
      end
      lga_pkg::ST_FIRST: state_nxt = lga_pkg::ST_CALC;
      lga_pkg::ST_CALC: begin
        if (last_row) begin
          state_nxt = lga_pkg::ST_DONE;
        end
      end
      lga_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = lga_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lga_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_rd_addr   = row_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = row_r;
    ram_wr_data   = rule_row;
    row_nxt       = row_r;
    out_load      = 1'b0;
    out_alive_val = 1'b0;
    out_step_val  = 1'b0;
    shift_rows    = 1'b0;
    load_cur      = 1'b0;
    cell_wr       = 1'b0;
    unique case (state_r)
      lga_pkg::ST_IDLE: begin
        if (func_in == lga_pkg::FN_STEP) begin
          ram_rd_addr = '0;
          row_nxt     = '0;
        end else begin
          ram_rd_addr = lga_pkg::ROW_W'(in_cell_row);
          row_nxt     = lga_pkg::ROW_W'(in_cell_row);
        end
      end
      lga_pkg::ST_CELL: begin
        ram_wr_data   = cell_row_mod;
        out_load      = out_free;
        out_alive_val = inrange_r && cell_row_mod[col_r];
        cell_wr       = out_free && inrange_r
                     && (func_r == lga_pkg::FN_SET || func_r == lga_pkg::FN_CLR);
        ram_wr_en     = cell_wr;
      end
      lga_pkg::ST_FIRST: begin
        ram_rd_addr = lga_pkg::ROW_W'(1);
        load_cur    = 1'b1;
      end
      lga_pkg::ST_CALC: begin
        ram_rd_addr = (int'(row_plus2) < lga_pkg::ROWS) ? row_plus2[lga_pkg::ROW_W-1:0] : '0;
        ram_wr_en   = 1'b1;
        shift_rows  = 1'b1;
        row_nxt     = last_row ? row_r : row_r + lga_pkg::ROW_W'(1);
      end
      lga_pkg::ST_DONE: begin
        out_load     = out_free;
        out_step_val = 1'b1;
      end
      default: ram_rd_addr = row_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lga_pkg::ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_wr_en) begin
        vld_r[ram_wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[ram_rd_addr];
    row_r    <= row_nxt;
    if (accept) begin
      func_r    <= func_in;
      col_r     <= lga_pkg::COL_W'(in_cell_col);
      inrange_r <= rd_in_range;
      prev_r    <= '0;
    end
    if (load_cur) begin
      cur_r <= rd_row;
    end
    if (shift_rows) begin
      prev_r <= cur_r;
      cur_r  <= lower_row;
    end
    if (out_load) begin
      out_alive_r     <= out_alive_val;
      out_step_done_r <= out_step_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_alive     = out_alive_r;
  assign out_step_done = out_step_done_r;

endmodule

// ===== test/life_automaton_grid_top_test.sv =====
// Self-checking testbench for the life automaton grid: cell writes, reads and B3/S23 steps.
`timescale 1ns / 1ps
module life_automaton_grid_top_test;

  localparam int NUM_CMDS   = 1225;
  localparam int CYCLE_CAP  = 400000;
  localparam int CALM_TAIL  = 150;

  typedef struct {
    lga_pkg::func_t            func;
    logic [lga_pkg::IDX_W-1:0] row;
    logic [lga_pkg::IDX_W-1:0] col;
  } grid_cmd_t;

  typedef struct {
    logic alive;
    logic step_done;
  } cell_answer_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [lga_pkg::FUNC_W-1:0]  in_func = '0;
  logic [lga_pkg::IDX_W-1:0]   in_cell_row = '0;
  logic [lga_pkg::IDX_W-1:0]   in_cell_col = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_alive;
  logic                        out_step_done;

  grid_cmd_t     cmd_queue[$];
  cell_answer_t  pending_answers[$];
  cell_answer_t  want;
  lga_pkg::row_t shadow_grid [lga_pkg::ROWS];

  int cycles = 0;
  int issued = 0;
  int in_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  int mismatches = 0;
  int n_steps = 0;
  int n_live = 0;
  int n_total = 0;

  life_automaton_grid_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_cell_row   (in_cell_row),
    .in_cell_col   (in_cell_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_alive     (out_alive),
    .out_step_done (out_step_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_cmd(lga_pkg::func_t f, int r, int c);
    grid_cmd_t cmd;
    cmd.func = f;
    cmd.row  = lga_pkg::IDX_W'(r);
    cmd.col  = lga_pkg::IDX_W'(c);
    cmd_queue.push_back(cmd);
  endfunction

  function automatic void advance_generation();
    lga_pkg::row_t prev [lga_pkg::ROWS];
    int   n, rr, cc;
    prev = shadow_grid;
    for (int r = 0; r < lga_pkg::ROWS; r++) begin
      for (int c = 0; c < lga_pkg::COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < lga_pkg::ROWS &&
                cc >= 0 && cc < lga_pkg::COLS && prev[rr][cc])
              n++;
          end
        end
        shadow_grid[r][c] = (n == int'(lga_pkg::BIRTH_CNT))
                         || (n == int'(lga_pkg::SURV_CNT) && prev[r][c]);
      end
    end
  endfunction

  function automatic cell_answer_t predict_answer(lga_pkg::func_t f, int r, int c);
    cell_answer_t ans;
    ans.alive = 1'b0;
    ans.step_done = 1'b0;
    if (f == lga_pkg::FN_STEP) begin
      advance_generation();
      ans.step_done = 1'b1;
    end else if (r < lga_pkg::ROWS && c < lga_pkg::COLS) begin
      if (f == lga_pkg::FN_SET)
        shadow_grid[r][c] = 1'b1;
      else if (f == lga_pkg::FN_CLR)
        shadow_grid[r][c] = 1'b0;
      ans.alive = shadow_grid[r][c];
    end
    return ans;
  endfunction

  // input driver
  always @(negedge clk) begin
    grid_cmd_t cmd;
    if (rst_n && !(in_valid && in_count < issued)) begin
      if (in_gap == 0 && cmd_queue.size() > CALM_TAIL && (issued / 64) % 4 != 3 &&
          $urandom_range(0, 5) == 0)
        in_gap = $urandom_range(1, 9);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cmd = cmd_queue.pop_front();
        in_valid    <= 1'b1;
        in_func     <= cmd.func;
        in_cell_row <= cmd.row;
        in_cell_col <= cmd.col;
        issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap == 0 && cmd_queue.size() > CALM_TAIL && (in_count / 80) % 4 != 1 &&
          $urandom_range(0, 5) == 0)
        out_gap = $urandom_range(1, 9);
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: checks results, then records each accepted command
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (out_alive !== want.alive) begin
            $error("alive: expected %0d, got %0d", want.alive, out_alive);
            mismatches++;
          end
          if (out_step_done !== want.step_done) begin
            $error("step_done: expected %0d, got %0d", want.step_done, out_step_done);
            mismatches++;
          end
          if (want.step_done)
            n_steps++;
          if (want.alive)
            n_live++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_answers.push_back(predict_answer(lga_pkg::func_t'(in_func),
                                                 int'(in_cell_row), int'(in_cell_col)));
        in_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int r0, c0, span;
    for (int r = 0; r < lga_pkg::ROWS; r++)
      shadow_grid[r] = '0;

    // corners, read, clear
    add_cmd(lga_pkg::FN_SET, 0, 0);
    add_cmd(lga_pkg::FN_SET, lga_pkg::ROWS - 1, lga_pkg::COLS - 1);
    add_cmd(lga_pkg::FN_SET, 0, lga_pkg::COLS - 1);
    add_cmd(lga_pkg::FN_SET, lga_pkg::ROWS - 1, 0);
    add_cmd(lga_pkg::FN_READ, 0, 0);
    add_cmd(lga_pkg::FN_READ, 7, 7);
    add_cmd(lga_pkg::FN_CLR, 0, 0);
    add_cmd(lga_pkg::FN_READ, 0, 0);
    // lone corner cells die; indices ignored on a step
    add_cmd(lga_pkg::FN_STEP, 15, 15);
    add_cmd(lga_pkg::FN_READ, lga_pkg::ROWS - 1, lga_pkg::COLS - 1);
    // blinker
    add_cmd(lga_pkg::FN_SET, 7, 6);
    add_cmd(lga_pkg::FN_SET, 7, 7);
    add_cmd(lga_pkg::FN_SET, 7, 8);
    add_cmd(lga_pkg::FN_STEP, 0, 0);
    add_cmd(lga_pkg::FN_READ, 6, 7);
    add_cmd(lga_pkg::FN_READ, 8, 7);
    add_cmd(lga_pkg::FN_READ, 7, 6);
    // plus shape: center has four neighbors and dies
    add_cmd(lga_pkg::FN_SET, 3, 3);
    add_cmd(lga_pkg::FN_SET, 2, 3);
    add_cmd(lga_pkg::FN_SET, 4, 3);
    add_cmd(lga_pkg::FN_SET, 3, 2);
    add_cmd(lga_pkg::FN_SET, 3, 4);
    add_cmd(lga_pkg::FN_STEP, 10, 5);
    add_cmd(lga_pkg::FN_READ, 3, 3);

    while (cmd_queue.size() < NUM_CMDS) begin
      if ($urandom_range(0, 9) < 7) begin
        // seed a window, run a few generations, probe around it
        r0 = $urandom_range(0, lga_pkg::ROWS - 1);
        c0 = $urandom_range(0, lga_pkg::COLS - 1);
        span = $urandom_range(3, 8);
        repeat ($urandom_range(span, span + span * span / 2))
          add_cmd(($urandom_range(0, 4) == 0) ? lga_pkg::FN_CLR : lga_pkg::FN_SET,
                  (r0 + $urandom_range(0, span - 1)) % lga_pkg::ROWS,
                  (c0 + $urandom_range(0, span - 1)) % lga_pkg::COLS);
        repeat ($urandom_range(1, 4)) begin
          add_cmd(lga_pkg::FN_STEP, $urandom_range(0, 15), $urandom_range(0, 15));
          repeat ($urandom_range(2, 8))
            add_cmd(lga_pkg::FN_READ, (r0 + $urandom_range(0, span + 1)) % lga_pkg::ROWS,
                    (c0 + $urandom_range(0, span + 1)) % lga_pkg::COLS);
        end
      end else begin
        repeat ($urandom_range(4, 12))
          add_cmd(lga_pkg::func_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                  $urandom_range(0, 15));
      end
    end
    n_total = cmd_queue.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_count < n_total || pending_answers.size() > 0)
      @(posedge clk);
    repeat (2 * lga_pkg::ROWS + 8) @(posedge clk);

    $display("Ran %0d commands through %0d generation steps; %0d results reported a live cell.",
             n_total, n_steps, n_live);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lga_pkg.sv
hdl/lga_ram.sv
hdl/lga_row_rule.sv
hdl/life_automaton_grid_top.sv
test/life_automaton_grid_top_test.sv
